[src/ovl_pkg.sv]
// shared types and codes for the ordered value list
package ovl_pkg;

  localparam int OVL_CAPACITY = 16;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_PREPEND = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_SEARCH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] entry_count;
  } out_item_t;

endpackage

[src/ovl_mem.sv]
// entry storage: one write port, one registered read port
module ovl_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ovl_ctrl.sv]
// command sequencer: walks the entry store one word per cycle with a shared comparator
module ovl_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  ovl_pkg::in_item_t in_data,
  output logic             idle,
  input  logic             out_free,
  output logic             done,
  output ovl_pkg::out_item_t res,
  output logic [CW-1:0]    count,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [31:0]      mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [31:0]      mem_rdata
);
  import ovl_pkg::*;

  state_t        state_r,  state_nxt;
  op_t           op_r,     op_nxt;
  logic [31:0]   val_r,    val_nxt;
  logic [CW-1:0] count_r,  count_nxt;
  logic [CW-1:0] idx_r,    idx_nxt;
  logic          issue_r,  issue_nxt;
  logic          pend_r,   pend_nxt;
  logic [AW-1:0] pidx_r,   pidx_nxt;
  logic [AW-1:0] pos_r,    pos_nxt;
  status_t       stat_r,   stat_nxt;

  logic          full;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] shift_start;
  logic [31:0]   pos_ext;
  logic [31:0]   count_ext;

  assign full        = (count_r == CW'(CAPACITY));
  assign idx_inc     = idx_r + CW'(1);
  assign shift_start = CW'(pidx_r) + CW'(1);
  assign pos_ext     = 32'(pos_r);
  assign count_ext   = 32'(count_r);

  assign count           = count_r;
  assign res.status      = stat_r;
  assign res.position    = pos_ext[3:0];
  assign res.entry_count = count_ext[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    pos_r  <= pos_nxt;
    stat_r <= stat_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    issue_nxt = issue_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = pidx_r;
    pos_nxt   = pos_r;
    stat_nxt  = stat_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = idx_r[AW-1:0];
    done      = 1'b0;
    idle      = 1'b0;

    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          op_nxt   = op_t'(in_data.operation);
          val_nxt  = in_data.value;
          pos_nxt  = '0;
          stat_nxt = STAT_OK;
          case (op_t'(in_data.operation))
            OP_APPEND, OP_PREPEND: begin
              if (full) begin
                stat_nxt  = STAT_FULL;
                state_nxt = S_DONE;
              end else if (op_t'(in_data.operation) == OP_APPEND || count_r == '0) begin
                // write straight at the back slot
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_data.value;
                pos_nxt   = count_r[AW-1:0];
                count_nxt = count_r + CW'(1);
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = count_r - CW'(1);
                issue_nxt = 1'b1;
                state_nxt = S_PREP;
              end
            end
            OP_REMOVE, OP_SEARCH: begin
              if (count_r == '0) begin
                stat_nxt  = STAT_EMPTY;
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = '0;
                issue_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_PREP: begin
        // move entries up by one, last first
        if (issue_r) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[AW-1:0];
          if (idx_r == '0) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - CW'(1);
          end
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_r + AW'(1);
          mem_wdata = mem_rdata;
        end
        if (!issue_r && !pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = val_r;
          pos_nxt   = '0;
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_SCAN: begin
        if (issue_r) begin
          mem_re    = 1'b1;
          pend_nxt  = 1'b1;
          pidx_nxt  = idx_r[AW-1:0];
          idx_nxt   = idx_inc;
          issue_nxt = (idx_inc < count_r);
        end
        if (pend_r) begin
          if (mem_rdata == val_r) begin
            // first match: drop the read in flight
            pos_nxt  = pidx_r;
            pend_nxt = 1'b0;
            if (op_r == OP_SEARCH) begin
              issue_nxt = 1'b0;
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = shift_start;
              issue_nxt = (shift_start < count_r);
              state_nxt = S_SHIFT;
            end
          end else if (!issue_r) begin
            stat_nxt  = STAT_NOT_FOUND;
            state_nxt = S_DONE;
          end
        end
      end

      S_SHIFT: begin
        // close the gap, moving entries down by one
        if (issue_r) begin
          mem_re    = 1'b1;
          pend_nxt  = 1'b1;
          pidx_nxt  = idx_r[AW-1:0];
          idx_nxt   = idx_inc;
          issue_nxt = (idx_inc < count_r);
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_r - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (!issue_r && !pend_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        done      = 1'b1;
        issue_nxt = 1'b0;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[src/ordered_value_list.sv]
// top level of the ordered value list: sequencer, entry store and result register
// A bounded ordered list of up to CAPACITY signed 32-bit values kept in a single-port-write,
// single-port-read memory. Each command (append, front insert, remove first match, search)
// gives one result transfer with status, position and the entry count afterwards. The block
// takes one command at a time and holds in_stall high until its result is in the output
// register. An append, a refused insert or a command on an empty list needs no walk of the
// store; a front insert moves every entry up by one, last first, through the memory's read
// and write ports before it writes the new value at the front; a search scans from the front
// up to the first match, or over every entry when nothing matches; a removal scans up to the
// first match and then moves the rest down by one. The memory's one read per cycle and the
// single comparator set the pace of each walk. The output register lets the next command
// start while a result still waits on out_stall.
module ordered_value_list #(
  parameter int CAPACITY = ovl_pkg::OVL_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ovl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ovl_pkg::out_item_t out_data
);
  import ovl_pkg::*;

  // address width for the store and width of the entry count
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          idle;
  logic          done;
  logic          out_free;
  out_item_t     res;
  logic [CW-1:0] count_w;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r;

  // busy from the accepted transfer until its result is registered
  assign in_stall = !idle;

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  ovl_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .idle      (idle),
    .out_free  (out_free),
    .done      (done),
    .res       (res),
    .count     (count_w),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ovl_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the entry count never goes beyond the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_w <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a command accepted leaves the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block ready right after a command transfer");

  // any status other than ok carries position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STAT_OK || out_data.position == 4'd0))
    else $error("nonzero position with a failing status");

  // an empty-list status reports no entries
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_EMPTY) |-> out_data.entry_count == 5'd0)
    else $error("empty status with nonzero entry count");

endmodule
